>>> hw/rtl/mhsp_pkg.sv
// Package: byte codes, event kinds, window codes and the result word type of the stream parser.
`timescale 1ns / 1ps
package mhsp_pkg;

  localparam logic [7:0] CODE_MSG_WIN    = 8'd1;
  localparam logic [7:0] CODE_RX_WIN     = 8'd2;
  localparam logic [7:0] CODE_ECHO_WIN   = 8'd3;
  localparam logic [7:0] CODE_PROMPT     = 8'd4;
  localparam logic [7:0] CODE_IGNORE     = 8'd7;
  localparam logic [7:0] CODE_STATUS     = 8'd30;
  localparam logic [7:0] CHAR_LF         = 8'd10;
  localparam logic [7:0] CHAR_CR         = 8'd13;
  localparam logic [7:0] PROMPT_MODE_LO  = 8'd32;
  localparam logic [7:0] PROMPT_MODE_HI  = 8'd37;
  localparam logic [2:0] PROMPT_UNKNOWN  = 3'd6;
  localparam logic [2:0] MODE_LISTEN     = 3'd6;
  localparam logic [7:0] PROMPT_LIMIT_RST = 8'd20;

  localparam int unsigned CFG_ADDR_W  = 3;
  localparam logic        REG_PROMPT_LIMIT = 1'b0;

  typedef enum logic [2:0] {
    EVT_STATUS      = 3'd0,
    EVT_PROMPT_MODE = 3'd1,
    EVT_PROMPT_END  = 3'd2,
    EVT_PROMPT_CHAR = 3'd3,
    EVT_RX_TEXT     = 3'd4,
    EVT_ECHO_TEXT   = 3'd5,
    EVT_MSG_TEXT    = 3'd6
  } evt_kind_t;

  typedef enum logic [1:0] {
    WIN_MESSAGE = 2'd0,
    WIN_RX      = 2'd1,
    WIN_ECHO    = 2'd2
  } win_t;

  typedef struct packed {
    evt_kind_t   event_kind;
    logic [7:0]  data_byte;
    logic        sending;
    logic [2:0]  link_status;
    logic [2:0]  link_mode;
    logic        listening;
    logic [2:0]  prompt_mode;
    logic        end_of_line;
  } evt_t;

endpackage

>>> hw/rtl/mhsp_in_if.sv
// Interface: input byte channel with valid/ready handshake.
`timescale 1ns / 1ps
interface mhsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> hw/rtl/mhsp_out_if.sv
// Interface: parsed event channel with valid/ready handshake.
`timescale 1ns / 1ps
interface mhsp_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_kind;
  logic [7:0] data_byte;
  logic       sending;
  logic [2:0] link_status;
  logic [2:0] link_mode;
  logic       listening;
  logic [2:0] prompt_mode;
  logic       end_of_line;

  modport source (output valid, output event_kind, output data_byte, output sending,
                  output link_status, output link_mode, output listening,
                  output prompt_mode, output end_of_line, input ready);
  modport sink   (input valid, input event_kind, input data_byte, input sending,
                  input link_status, input link_mode, input listening,
                  input prompt_mode, input end_of_line, output ready);
endinterface

>>> hw/rtl/modem_host_stream_parser.sv
// An accepted byte's event word is registered into the main or the skid output word.
// Throughput: one byte per cycle; decode is a single pass into a two-word output buffer.
// The input stalls only when both output buffer words are full.
// Reset (rst_n low, synchronous): pending flags and prompt count clear, window is
// message, prompt text limit returns to 20, output buffer empties.
`timescale 1ns / 1ps
module modem_host_stream_parser (
  input  logic                               clk,
  input  logic                               rst_n,
  mhsp_in_if.sink                            in_stream,
  mhsp_out_if.source                         out_stream,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [mhsp_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [31:0]                        cfg_pwdata,
  output logic [31:0]                        cfg_prdata,
  output logic                               cfg_pready
);
  import mhsp_pkg::*;

  logic       limit_sel;
  logic [7:0] prompt_limit_r;
  logic       status_pending_r, status_pending_nxt;
  logic       prompt_pending_r, prompt_pending_nxt;
  logic [7:0] prompt_left_r, prompt_left_nxt;
  win_t       window_r, window_nxt;

  evt_t       evt;
  logic       has_evt;
  logic       accept;
  logic       pop;
  logic       push;

  evt_t       main_r;
  logic       main_v_r;
  evt_t       skid_r;
  logic       skid_v_r;

  logic [7:0] b;
  logic [2:0] mode;

  assign limit_sel  = (cfg_paddr[2] == REG_PROMPT_LIMIT);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = limit_sel ? {24'd0, prompt_limit_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prompt_limit_r <= PROMPT_LIMIT_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && limit_sel) begin
      prompt_limit_r <= cfg_pwdata[7:0];
    end
  end

  assign b      = in_stream.rx_byte;
  assign mode   = b[6:4];
  assign accept = in_stream.valid && in_stream.ready;

  always_comb begin
    evt                = '0;
    evt.data_byte      = b;
    has_evt            = 1'b0;
    status_pending_nxt = status_pending_r;
    prompt_pending_nxt = prompt_pending_r;
    prompt_left_nxt    = prompt_left_r;
    window_nxt         = window_r;
    if (status_pending_r) begin
      status_pending_nxt = 1'b0;
      has_evt            = 1'b1;
      evt.event_kind     = EVT_STATUS;
      evt.sending        = b[3];
      evt.link_status    = b[2:0];
      evt.link_mode      = mode;
      evt.listening      = (mode == MODE_LISTEN);
    end else if (b == CODE_STATUS) begin
      status_pending_nxt = 1'b1;
    end else if (b == CODE_PROMPT) begin
      prompt_pending_nxt = 1'b1;
    end else if (prompt_pending_r) begin
      prompt_pending_nxt = 1'b0;
      prompt_left_nxt    = prompt_limit_r;
      has_evt            = 1'b1;
      evt.event_kind     = EVT_PROMPT_MODE;
      evt.prompt_mode    = (b inside {[PROMPT_MODE_LO:PROMPT_MODE_HI]}) ?
                           3'(b - PROMPT_MODE_LO) : PROMPT_UNKNOWN;
    end else if (prompt_left_r != 8'd0) begin
      if (b == CODE_MSG_WIN) begin
        prompt_left_nxt = 8'd0;
        window_nxt      = WIN_MESSAGE;
        has_evt         = 1'b1;
        evt.event_kind  = EVT_PROMPT_END;
      end else begin
        prompt_left_nxt = prompt_left_r - 8'd1;
        if (b inside {CHAR_LF, CHAR_CR}) begin
          has_evt        = 1'b1;
          evt.event_kind = EVT_PROMPT_CHAR;
        end
      end
    end else if (b == CODE_ECHO_WIN) begin
      window_nxt = WIN_ECHO;
    end else if (b == CODE_RX_WIN) begin
      window_nxt = WIN_RX;
    end else if (b == CODE_MSG_WIN) begin
      window_nxt = WIN_MESSAGE;
    end else if (b != CODE_IGNORE) begin
      has_evt = 1'b1;
      case (window_r)
        WIN_RX: begin
          evt.event_kind = EVT_RX_TEXT;
        end
        WIN_ECHO: begin
          evt.event_kind = EVT_ECHO_TEXT;
        end
        default: begin
          evt.event_kind  = EVT_MSG_TEXT;
          evt.end_of_line = (b inside {CHAR_LF, CHAR_CR});
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_pending_r <= 1'b0;
      prompt_pending_r <= 1'b0;
      prompt_left_r    <= 8'd0;
      window_r         <= WIN_MESSAGE;
    end else if (accept) begin
      status_pending_r <= status_pending_nxt;
      prompt_pending_r <= prompt_pending_nxt;
      prompt_left_r    <= prompt_left_nxt;
      window_r         <= window_nxt;
    end
  end

  assign in_stream.ready = !skid_v_r;
  assign push            = accept && has_evt;
  assign pop             = main_v_r && out_stream.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (pop) begin
      if (skid_v_r) begin
        skid_v_r <= 1'b0;
      end else begin
        main_v_r <= push;
      end
    end else if (!main_v_r) begin
      main_v_r <= push;
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_v_r) begin
        main_r <= skid_r;
      end else begin
        main_r <= evt;
      end
    end else if (!main_v_r) begin
      main_r <= evt;
    end else if (push) begin
      skid_r <= evt;
    end
  end

  assign out_stream.valid       = main_v_r;
  assign out_stream.event_kind  = main_r.event_kind;
  assign out_stream.data_byte   = main_r.data_byte;
  assign out_stream.sending     = main_r.sending;
  assign out_stream.link_status = main_r.link_status;
  assign out_stream.link_mode   = main_r.link_mode;
  assign out_stream.listening   = main_r.listening;
  assign out_stream.prompt_mode = main_r.prompt_mode;
  assign out_stream.end_of_line = main_r.end_of_line;

endmodule
